// ----- rtl/gdd_pkg.sv -----
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 12;
    localparam int QUOT_W    = 6;
    localparam int MPOS_W    = 4;
    localparam int DAYNUM_W  = 21;
    localparam int RESULT_W  = 22;
    localparam int MAX_YEAR_DEFAULT = 4095;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // days in month, February as a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // days before month, year starting in March: (153*mp + 2) / 5
    function automatic logic [8:0] march_offset(input logic [MPOS_W-1:0] mp);
        logic [8:0] off;
        begin
            case (mp)
                4'd0:    off = 9'd0;
                4'd1:    off = 9'd31;
                4'd2:    off = 9'd61;
                4'd3:    off = 9'd92;
                4'd4:    off = 9'd122;
                4'd5:    off = 9'd153;
                4'd6:    off = 9'd184;
                4'd7:    off = 9'd214;
                4'd8:    off = 9'd245;
                4'd9:    off = 9'd275;
                4'd10:   off = 9'd306;
                4'd11:   off = 9'd337;
                default: off = 9'd0;
            endcase
            return off;
        end
    endfunction

    // floor(y / 100) for a 12-bit year: (y/4) * 41 / 1024 is exact below 1024
    function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [15:0] prod;
        begin
            prod = 16'(y[YEAR_W-1:2]) * 16'd41;
            return prod[15:10];
        end
    endfunction

endpackage

// ----- rtl/gregorian_date_difference.sv -----
`timescale 1ns / 1ps

// Signed day count between two Gregorian dates. One date pair is taken per
// cycle while in_ready is high. Stage one checks ranges and forms the
// quotients by 100, stage two applies the leap rule and builds each date's
// serial day number, stage three subtracts, applies the end-day increment and
// saturates. A stall at the output holds the pipeline; bubbles are squeezed
// out, so the block keeps accepting while any stage is empty. An impossible
// date (day, month or year out of range) sets date_invalid and gives 0.

module gregorian_date_difference
    import gdd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [DAY_W-1:0]           start_day,
    input  logic [MONTH_W-1:0]         start_month,
    input  logic [YEAR_W-1:0]          start_year,
    input  logic [DAY_W-1:0]           end_day,
    input  logic [MONTH_W-1:0]         end_month,
    input  logic [YEAR_W-1:0]          end_year,
    input  logic                       include_end_day,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] days_between,
    output logic                       date_invalid
);

    localparam int DIFF_W = DAYNUM_W + 2;
    localparam logic signed [DIFF_W-1:0] OUT_MAX = DIFF_W'((1 <<< (RESULT_W - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] OUT_MIN = -DIFF_W'(1 <<< (RESULT_W - 1));

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic inc1_reg, inc2_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            inc1_reg <= include_end_day;
        if (en2)
            inc2_reg <= inc1_reg;
    end

    logic [DAYNUM_W-1:0] start_num, end_num;
    logic                start_ok, end_ok;

    gdd_date_pipe #(.MAX_YEAR(MAX_YEAR)) u_start
    (
        .clk     (clk),
        .en1     (en1),
        .en2     (en2),
        .day     (start_day),
        .month   (start_month),
        .year    (start_year),
        .day_num (start_num),
        .date_ok (start_ok)
    );

    gdd_date_pipe #(.MAX_YEAR(MAX_YEAR)) u_end
    (
        .clk     (clk),
        .en1     (en1),
        .en2     (en2),
        .day     (end_day),
        .month   (end_month),
        .year    (end_year),
        .day_num (end_num),
        .date_ok (end_ok)
    );

    // stage 3: difference, end-day increment, saturation
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   adj;
    logic signed [RESULT_W-1:0] days_next;
    logic                       invalid_next;
    logic signed [RESULT_W-1:0] days_reg;
    logic                       invalid_reg;

    always_comb
    begin
        diff = signed'(DIFF_W'(end_num)) - signed'(DIFF_W'(start_num));
        if (end_num > start_num)
            adj = diff + DIFF_W'(inc2_reg);
        else if (end_num < start_num)
            adj = diff - DIFF_W'(inc2_reg);
        else
            adj = '0;
        invalid_next = !(start_ok && end_ok);
        if (invalid_next)
            days_next = '0;
        else if (adj > OUT_MAX)
            days_next = OUT_MAX[RESULT_W-1:0];
        else if (adj < OUT_MIN)
            days_next = OUT_MIN[RESULT_W-1:0];
        else
            days_next = adj[RESULT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            days_reg    <= days_next;
            invalid_reg <= invalid_next;
        end
    end

    assign out_valid    = v3_reg;
    assign days_between = days_reg;
    assign date_invalid = invalid_reg;

endmodule

// ----- rtl/gdd_date_pipe.sv -----
`timescale 1ns / 1ps

module gdd_date_pipe
    import gdd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEFAULT
)
(
    input  logic                clk,
    input  logic                en1,
    input  logic                en2,
    input  logic [DAY_W-1:0]    day,
    input  logic [MONTH_W-1:0]  month,
    input  logic [YEAR_W-1:0]   year,
    output logic [DAYNUM_W-1:0] day_num,
    output logic                date_ok
);

    // stage 1: range checks, March-based year, divisions by 100
    logic [YEAR_W-1:0]   yy_next;
    logic [MPOS_W-1:0]   mp_next;
    logic                pre_ok_next;

    logic [DAY_W-1:0]    day_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [YEAR_W-1:0]   yy_reg;
    logic [QUOT_W-1:0]   qy_reg;
    logic [QUOT_W-1:0]   qyy_reg;
    logic [MPOS_W-1:0]   mp_reg;
    logic                pre_ok_reg;

    always_comb
    begin
        yy_next     = (month <= MONTH_FEB) ? year - 12'd1 : year;
        mp_next     = (month > MONTH_FEB) ? month - 4'd3 : month + 4'd9;
        pre_ok_next = (month >= MONTH_JAN) && (month <= MONTH_DEC) && (year != '0)
                      && (32'(year) <= 32'(MAX_YEAR)) && (day != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            day_reg    <= day;
            month_reg  <= month;
            year_reg   <= year;
            yy_reg     <= yy_next;
            qy_reg     <= div100(year);
            qyy_reg    <= div100(yy_next);
            mp_reg     <= mp_next;
            pre_ok_reg <= pre_ok_next;
        end
    end

    // stage 2: leap rule, month length, serial day number
    logic [YEAR_W-1:0]   rem100;
    logic                leap;
    logic [DAY_W-1:0]    len;
    logic                ok_next;
    logic [DAYNUM_W-1:0] num_next;

    logic [DAYNUM_W-1:0] num_reg;
    logic                ok_reg;

    always_comb
    begin
        rem100   = year_reg - 12'(qy_reg) * 12'd100;
        leap     = ((year_reg[1:0] == 2'b00) && (rem100 != '0))
                   || ((rem100 == '0) && (qy_reg[1:0] == 2'b00));
        len      = (month_reg == MONTH_FEB && leap) ? 5'd29 : month_len(month_reg);
        ok_next  = pre_ok_reg && (day_reg <= len);
        num_next = DAYNUM_W'(yy_reg) * DAYNUM_W'(365)
                 + DAYNUM_W'(yy_reg[YEAR_W-1:2])
                 - DAYNUM_W'(qyy_reg)
                 + DAYNUM_W'(qyy_reg[QUOT_W-1:2])
                 + DAYNUM_W'(march_offset(mp_reg))
                 + DAYNUM_W'(day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            num_reg <= num_next;
            ok_reg  <= ok_next;
        end
    end

    assign day_num = num_reg;
    assign date_ok = ok_reg;

endmodule

// ----- test/tb_gregorian_date_difference.sv -----
`timescale 1ns / 1ps

module tb_gregorian_date_difference;
    import gdd_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 80;
    localparam int RANDOM_PAIRS = 600;

    typedef struct packed {
        logic [DAY_W-1:0]   sd;
        logic [MONTH_W-1:0] sm;
        logic [YEAR_W-1:0]  sy;
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  ey;
        logic               inc;
        logic               drain;
    } date_pair_t;

    typedef struct packed {
        logic [RESULT_W-1:0] days;
        logic                bad;
    } span_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [DAY_W-1:0]           start_day = '0;
    logic [MONTH_W-1:0]         start_month = '0;
    logic [YEAR_W-1:0]          start_year = '0;
    logic [DAY_W-1:0]           end_day = '0;
    logic [MONTH_W-1:0]         end_month = '0;
    logic [YEAR_W-1:0]          end_year = '0;
    logic                       include_end_day = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [RESULT_W-1:0] days_between;
    logic                       date_invalid;

    date_pair_t  date_pairs[$];
    span_t       pending_spans[$];
    int unsigned cycle_cnt = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;
    int unsigned err_cnt = 0;
    int unsigned n_checked = 0;
    int unsigned n_bad = 0;
    int unsigned n_fwd = 0;
    int unsigned n_back = 0;
    int unsigned n_same = 0;
    logic        calm_tx;
    logic        calm_rx;

    gregorian_date_difference u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .start_day       (start_day),
        .start_month     (start_month),
        .start_year      (start_year),
        .end_day         (end_day),
        .end_month       (end_month),
        .end_year        (end_year),
        .include_end_day (include_end_day),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .days_between    (days_between),
        .date_invalid    (date_invalid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign calm_tx = (cycle_cnt % 3000) < 500;
    assign calm_rx = ((cycle_cnt + 1500) % 3000) < 500;

    function automatic bit is_leap(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            4, 6, 9, 11: return 30;
            int'(MONTH_FEB): return is_leap(y) ? 29 : 28;
            default: return 31;
        endcase
    endfunction

    function automatic bit date_real(input int d, input int m, input int y);
        if (m < 1 || m > 12 || y < 1 || y > MAX_YEAR_DEFAULT || d < 1)
            return 1'b0;
        return d <= month_days(m, y);
    endfunction

    // days since 31 Dec of year 0 in the proleptic calendar
    function automatic longint serial_day(input int d, input int m, input int y);
        longint n;
        longint py;
        int     k;
        py = y - 1;
        n = 365 * py + py / 4 - py / 100 + py / 400;
        for (k = 1; k < m; k++)
            n += month_days(k, y);
        return n + d;
    endfunction

    function automatic span_t span_of(input int sd, input int sm, input int sy,
                                      input int ed, input int em, input int ey,
                                      input bit inc);
        span_t  r;
        longint a;
        longint b;
        longint diff;
        r.days = '0;
        r.bad  = 1'b0;
        if (!date_real(sd, sm, sy) || !date_real(ed, em, ey))
        begin
            r.bad = 1'b1;
        end
        else
        begin
            a = serial_day(sd, sm, sy);
            b = serial_day(ed, em, ey);
            if (b > a)
                diff = (b - a) + longint'(inc);
            else if (b < a)
                diff = -((a - b) + longint'(inc));
            else
                diff = 0;
            if (diff > 2097151)
                diff = 2097151;
            if (diff < -2097152)
                diff = -2097152;
            r.days = diff[RESULT_W-1:0];
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap(input bit calm, input int unsigned idle_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r >= idle_pct)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_pair(input int sd, input int sm, input int sy,
                            input int ed, input int em, input int ey,
                            input bit inc, input bit drain);
        date_pair_t p;
        p.sd    = DAY_W'(sd);
        p.sm    = MONTH_W'(sm);
        p.sy    = YEAR_W'(sy);
        p.ed    = DAY_W'(ed);
        p.em    = MONTH_W'(em);
        p.ey    = YEAR_W'(ey);
        p.inc   = inc;
        p.drain = drain;
        date_pairs.push_back(p);
    endtask

    function automatic int pick_year();
        int r;
        r = $urandom_range(99);
        if (r < 12)
        begin
            case ($urandom_range(9))
                0: return 1;
                1: return MAX_YEAR_DEFAULT;
                2: return 100;
                3: return 400;
                4: return 1600;
                5: return 1900;
                6: return 2000;
                7: return 2100;
                8: return 4000;
                default: return 4 * $urandom_range(1, 1023);
            endcase
        end
        return $urandom_range(1, MAX_YEAR_DEFAULT);
    endfunction

    task automatic rand_date(input int y, output int d, output int m);
        m = $urandom_range(1, 12);
        if ($urandom_range(4) == 0)
            d = month_days(m, y);
        else
            d = $urandom_range(1, month_days(m, y));
    endtask

    // make a real date impossible: day just past a short month, else month 13 to 15
    task automatic spoil_date(inout int d, inout int m, input int y);
        if (month_days(m, y) == 31)
            m = $urandom_range(13, 15);
        else
            d = month_days(m, y) + 1;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_pairs
        date_pair_t p;
        logic       fire;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end
        else
        begin
            fire = in_valid && in_ready;
            if (!in_valid || fire)
            begin
                if (tx_gap != 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (date_pairs.size() != 0 &&
                         !(date_pairs[0].drain && (pending_spans.size() != 0 || fire)))
                begin
                    p = date_pairs.pop_front();
                    start_day       <= p.sd;
                    start_month     <= p.sm;
                    start_year      <= p.sy;
                    end_day         <= p.ed;
                    end_month       <= p.em;
                    end_year        <= p.ey;
                    include_end_day <= p.inc;
                    in_valid        <= 1'b1;
                    tx_gap          <= pick_gap(calm_tx, 35);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        int unsigned g;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
        end
        else if (rx_hold != 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            g = pick_gap(calm_rx, 25);
            out_ready <= (g == 0);
            if (g != 0)
                rx_hold <= g - 1;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin : watch_spans
        span_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_spans.push_back(span_of(start_day, start_month, start_year,
                                                end_day, end_month, end_year,
                                                include_end_day));
            if (out_valid && out_ready)
            begin
                if (pending_spans.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t unexpected result: days_between %0d date_invalid %0b",
                             $time, days_between, date_invalid);
                end
                else
                begin
                    want = pending_spans.pop_front();
                    n_checked++;
                    if (want.bad)
                        n_bad++;
                    else if ($signed(want.days) > 0)
                        n_fwd++;
                    else if ($signed(want.days) < 0)
                        n_back++;
                    else
                        n_same++;
                    if (days_between !== want.days)
                    begin
                        err_cnt++;
                        $display("%0t days_between mismatch: expected %0d actual %0d",
                                 $time, $signed(want.days), days_between);
                    end
                    if (date_invalid !== want.bad)
                    begin
                        err_cnt++;
                        $display("%0t date_invalid mismatch: expected %0b actual %0b",
                                 $time, want.bad, date_invalid);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d results outstanding", $time, pending_spans.size());
            $display("tb_gregorian_date_difference: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int sd;
        int sm;
        int sy;
        int ed;
        int em;
        int ey;
        int r;
        int i;
        bit inc;

        add_pair(1, 1, 1, 1, 1, 1, 1, 0);
        add_pair(15, 6, 2024, 15, 6, 2024, 1, 0);
        add_pair(1, 1, 1, 31, 12, 4095, 1, 0);
        add_pair(31, 12, 4095, 1, 1, 1, 1, 0);
        add_pair(1, 1, 1, 31, 12, 4095, 0, 0);
        add_pair(31, 12, 4095, 1, 1, 1, 0, 0);
        add_pair(28, 2, 2000, 29, 2, 2000, 0, 0);
        add_pair(29, 2, 2000, 1, 3, 2000, 1, 0);
        add_pair(29, 2, 1900, 1, 3, 1900, 0, 0);
        add_pair(28, 2, 2100, 1, 3, 2100, 0, 0);
        add_pair(29, 2, 2024, 29, 2, 2023, 0, 0);
        add_pair(0, 1, 2000, 1, 1, 2000, 0, 0);
        add_pair(1, 0, 2000, 1, 1, 2000, 0, 0);
        add_pair(1, 1, 2000, 1, 13, 2000, 0, 0);
        add_pair(1, 15, 4095, 1, 1, 2000, 1, 0);
        add_pair(1, 1, 0, 1, 1, 1, 0, 0);
        add_pair(31, 4, 2001, 1, 5, 2001, 0, 0);
        add_pair(1, 5, 2001, 31, 6, 2001, 0, 0);
        add_pair(31, 1, 4095, 31, 12, 4095, 1, 0);
        add_pair(31, 12, 1999, 1, 1, 2000, 1, 1);
        add_pair(1, 3, 1600, 28, 2, 1600, 0, 0);
        add_pair(1, 3, 1600, 29, 2, 1600, 1, 0);
        add_pair(31, 15, 4095, 31, 15, 4095, 1, 0);
        add_pair(30, 2, 2000, 1, 1, 2000, 0, 0);

        for (i = 0; i < RANDOM_PAIRS; i++)
        begin
            r   = $urandom_range(99);
            inc = $urandom_range(1);
            sy  = pick_year();
            rand_date(sy, sd, sm);
            if (r < 12)
            begin
                sd = $urandom_range(31);
                sm = $urandom_range(15);
                sy = $urandom_range(MAX_YEAR_DEFAULT);
                ed = $urandom_range(31);
                em = $urandom_range(15);
                ey = $urandom_range(MAX_YEAR_DEFAULT);
            end
            else if (r < 28)
            begin
                ed = sd;
                em = sm;
                ey = sy;
            end
            else if (r < 60)
            begin
                ey = sy + $urandom_range(2) - 1;
                if (ey < 1 || ey > MAX_YEAR_DEFAULT)
                    ey = sy;
                rand_date(ey, ed, em);
            end
            else
            begin
                ey = pick_year();
                rand_date(ey, ed, em);
            end
            if (r >= 12 && r < 20)
            begin
                if ($urandom_range(1))
                    spoil_date(sd, sm, sy);
                else
                    spoil_date(ed, em, ey);
            end
            add_pair(sd, sm, sy, ed, em, ey, inc, i == RANDOM_PAIRS / 2);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (date_pairs.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d date pairs: %0d with an impossible date, %0d forward,",
                 n_checked, n_bad, n_fwd);
        $display("%0d backward and %0d same day, under random stalls on both sides",
                 n_back, n_same);
        if (err_cnt == 0)
            $display("tb_gregorian_date_difference: done, clean");
        else
            $display("tb_gregorian_date_difference: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gdd_pkg.sv
rtl/gdd_date_pipe.sv
rtl/gregorian_date_difference.sv
test/tb_gregorian_date_difference.sv
